@@ design/voxel_grid_ray_walker_defines.svh @@
// Assertion macros for the voxel grid ray walker checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VOXEL_GRID_RAY_WALKER_DEFINES_SVH
`define VOXEL_GRID_RAY_WALKER_DEFINES_SVH

// same-cycle implication
`define VGRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VGRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/vgrw_pkg.sv @@
// Shared types and constants of the voxel grid ray walker.
// No dependencies.
`default_nettype none
package vgrw_pkg;

  localparam logic [30:0] T_MAX      = 31'h7FFFFFFF;
  localparam int          DIV_NUM_W  = 49;
  localparam int          DIV_DEN_W  = 32;
  localparam int          MAX_VISITS = 46;
  localparam int          CNT_W      = 6;
  localparam int          CFG_IDX_W  = 3;
  localparam logic [1:0]  AX_LAST    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WID_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WID_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WID_Z = 3'd5;

  typedef enum logic [1:0] {OP_CELL, OP_CS, OP_NEXT, OP_STEP} op_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic       cs_load;
    op_t        op;
    logic [1:0] ax;
    logic       walk;
    logic       load_miss;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic walk_end;
  } sts_t;

endpackage
`default_nettype wire

@@ design/vgrw_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on vgrw_pkg.
`default_nettype none
module vgrw_div import vgrw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [30:0]               quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [5:0]           cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [31:0]          rem_r;
  logic [32:0]          trial;
  logic [32:0]          rem_nxt;
  logic                 ge;

  assign trial   = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt[31:0];
      q_r   <= {q_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = (|q_r[DIV_NUM_W-1:31]) ? T_MAX : q_r[30:0];

endmodule
`default_nettype wire

@@ design/vgrw_dp.sv @@
// Datapath: grid registers, ray setup operands, shared divider, walk state, result register.
// Depends on vgrw_pkg and vgrw_div.
`default_nettype none
module vgrw_dp import vgrw_pkg::*; #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic signed [31:0]   in_origin_x,
  input  wire logic signed [31:0]   in_origin_y,
  input  wire logic signed [31:0]   in_origin_z,
  input  wire logic signed [31:0]   in_entry_x,
  input  wire logic signed [31:0]   in_entry_y,
  input  wire logic signed [31:0]   in_entry_z,
  input  wire logic signed [31:0]   in_dir_x,
  input  wire logic signed [31:0]   in_dir_y,
  input  wire logic signed [31:0]   in_dir_z,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [3:0]                out_cell_x,
  output logic [3:0]                out_cell_y,
  output logic [3:0]                out_cell_z,
  output logic [11:0]               out_cell_index,
  output logic [30:0]               out_t_limit,
  output logic                      out_missed,
  output logic                      out_last
);

  // reciprocals ceil(2^35 / n) for the cell size
  localparam logic [35:0] RCP_X = 36'(((64'd1 << 35) + 64'(CELLS_X) - 64'd1) / 64'(CELLS_X));
  localparam logic [35:0] RCP_Y = 36'(((64'd1 << 35) + 64'(CELLS_Y) - 64'd1) / 64'(CELLS_Y));
  localparam logic [35:0] RCP_Z = 36'(((64'd1 << 35) + 64'(CELLS_Z) - 64'd1) / 64'(CELLS_Z));

  function automatic logic [30:0] cs_of(input logic [30:0] w, input logic [35:0] rcp);
    logic [30:0] w1;
    logic [66:0] prod;
    w1   = (w == '0) ? 31'd1 : w;
    prod = 67'(w1) * 67'(rcp);
    return prod[65:35];
  endfunction

  logic signed [31:0] min_r  [0:2];
  logic [30:0]        wid_r  [0:2];
  logic signed [31:0] pt_r   [0:2];
  logic signed [31:0] dir_r  [0:2];
  logic [5:0]         cell_r [0:2];
  logic [30:0]        nc_r   [0:2];
  logic [30:0]        cstep_r[0:2];
  logic [2:0]         neg_r;
  logic [30:0]        cs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;

  logic signed [31:0] org [0:2];
  logic signed [31:0] ent [0:2];
  logic signed [31:0] dirin [0:2];
  logic [4:0]         ax_n [0:2];
  logic [30:0]        cs_ax [0:2];
  logic [2:0]         org_in;

  assign org[0] = in_origin_x;  assign org[1] = in_origin_y;  assign org[2] = in_origin_z;
  assign ent[0] = in_entry_x;   assign ent[1] = in_entry_y;   assign ent[2] = in_entry_z;
  assign dirin[0] = in_dir_x;   assign dirin[1] = in_dir_y;   assign dirin[2] = in_dir_z;
  assign ax_n[0] = 5'(CELLS_X); assign ax_n[1] = 5'(CELLS_Y); assign ax_n[2] = 5'(CELLS_Z);
  assign cs_ax[0] = cs_of(wid_r[0], RCP_X);
  assign cs_ax[1] = cs_of(wid_r[1], RCP_Y);
  assign cs_ax[2] = cs_of(wid_r[2], RCP_Z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org_in[i] = ($signed({{2{org[i][31]}}, org[i]}) > $signed({{2{min_r[i][31]}}, min_r[i]}))
               && ($signed({{2{org[i][31]}}, org[i]}) <
                   ($signed({{2{min_r[i][31]}}, min_r[i]}) + $signed({3'b0, wid_r[i]})));
    end
  end

  // current setup axis operands
  logic signed [31:0] a_min, a_p, a_d;
  logic [30:0]        a_w;
  logic [30:0]        a_cs;
  logic [4:0]         a_n;
  logic [5:0]         a_cell;

  always_comb begin
    a_min  = min_r[2];
    a_p    = pt_r[2];
    a_d    = dir_r[2];
    a_w    = wid_r[2];
    a_cs   = cs_ax[2];
    a_n    = ax_n[2];
    a_cell = cell_r[2];
    for (int i = 0; i < 2; i++) begin
      if (cmd.ax == 2'(i)) begin
        a_min  = min_r[i];
        a_p    = pt_r[i];
        a_d    = dir_r[i];
        a_w    = wid_r[i];
        a_cs   = cs_ax[i];
        a_n    = ax_n[i];
        a_cell = cell_r[i];
      end
    end
  end

  logic [30:0]        w_eff;
  logic signed [33:0] off;
  logic [37:0]        cell_num;
  logic [4:0]         c_inc;
  logic [35:0]        plane_off;
  logic signed [36:0] plane;
  logic signed [36:0] pl_dist;
  logic [36:0]        dist_abs;
  logic [31:0]        ad;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic               div_done;
  logic [30:0]        quo;
  logic [5:0]         nm1;

  assign w_eff     = (a_w == '0) ? 31'd1 : a_w;
  assign off       = $signed({{2{a_p[31]}}, a_p}) - $signed({{2{a_min[31]}}, a_min});
  assign cell_num  = (off > 0) ? ({5'b0, off[32:0]} * {33'b0, a_n}) : '0;
  assign c_inc     = {1'b0, a_cell[3:0]} + {4'b0, ~a_d[31]};
  assign plane_off = {5'b0, cs_r} * {31'b0, c_inc};
  assign plane     = $signed({{5{a_min[31]}}, a_min}) + $signed({1'b0, plane_off});
  assign pl_dist   = plane - $signed({{5{a_p[31]}}, a_p});
  assign dist_abs  = pl_dist[36] ? 37'(-pl_dist) : 37'(pl_dist);
  assign ad        = a_d[31] ? (~a_d + 32'd1) : a_d;
  assign nm1       = 6'(a_n) - 6'd1;

  always_comb begin
    case (cmd.op)
      OP_CELL: begin
        div_num = DIV_NUM_W'(cell_num);
        div_den = {1'b0, w_eff};
      end
      OP_NEXT: begin
        div_num = {dist_abs[32:0], 16'b0};
        div_den = ad;
      end
      default: begin
        div_num = {2'b0, cs_r, 16'b0};
        div_den = ad;
      end
    endcase
  end

  vgrw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // walk step
  logic       sel_x, sel_y;
  logic [1:0] k;
  logic [30:0] lim;
  logic [31:0] nc_sum;
  logic [30:0] nc_new;
  logic [5:0]  cell_new;
  logic        oob;
  logic        walk_end;
  logic [11:0] idx;

  assign sel_x = (nc_r[0] < nc_r[1]) && (nc_r[0] < nc_r[2]);
  assign sel_y = !sel_x && (nc_r[1] < nc_r[2]);

  always_comb begin
    k = sel_x ? 2'd0 : (sel_y ? 2'd1 : 2'd2);
    lim = nc_r[2];
    nc_sum = {1'b0, nc_r[2]} + {1'b0, cstep_r[2]};
    cell_new = neg_r[2] ? (cell_r[2] - 6'd1) : (cell_r[2] + 6'd1);
    oob = cell_new >= 6'(CELLS_Z);
    if (sel_x) begin
      lim = nc_r[0];
      nc_sum = {1'b0, nc_r[0]} + {1'b0, cstep_r[0]};
      cell_new = neg_r[0] ? (cell_r[0] - 6'd1) : (cell_r[0] + 6'd1);
      oob = cell_new >= 6'(CELLS_X);
    end else if (sel_y) begin
      lim = nc_r[1];
      nc_sum = {1'b0, nc_r[1]} + {1'b0, cstep_r[1]};
      cell_new = neg_r[1] ? (cell_r[1] - 6'd1) : (cell_r[1] + 6'd1);
      oob = cell_new >= 6'(CELLS_Y);
    end
  end

  assign nc_new   = nc_sum[31] ? T_MAX : nc_sum[30:0];
  assign walk_end = oob || (cnt_r == CNT_W'(MAX_VISITS - 1));
  assign idx = 12'(cell_r[0][3:0]) + 12'(cell_r[1][3:0]) * 12'(CELLS_X)
             + 12'(cell_r[2][3:0]) * 12'(CELLS_X * CELLS_Y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r[0] <= '0;
      min_r[1] <= '0;
      min_r[2] <= '0;
      wid_r[0] <= 31'd65536;
      wid_r[1] <= 31'd65536;
      wid_r[2] <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X: min_r[0] <= cfg_data;
        REG_MIN_Y: min_r[1] <= cfg_data;
        REG_MIN_Z: min_r[2] <= cfg_data;
        REG_WID_X: wid_r[0] <= cfg_data[30:0];
        REG_WID_Y: wid_r[1] <= cfg_data[30:0];
        REG_WID_Z: wid_r[2] <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < 3; i++) begin
        pt_r[i]  <= (&org_in) ? org[i] : ent[i];
        dir_r[i] <= dirin[i];
      end
    end
    if (cmd.cs_load) begin
      cs_r <= a_cs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cell_r[i]  <= '0;
        nc_r[i]    <= '0;
        cstep_r[i] <= '0;
      end
      neg_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.accept) begin
        cnt_r <= '0;
      end
      if (div_done) begin
        for (int i = 0; i < 3; i++) begin
          if (cmd.ax == 2'(i)) begin
            case (cmd.op)
              OP_CELL: cell_r[i] <= ({1'b0, quo} > {26'b0, nm1}) ? nm1 : quo[5:0];
              OP_NEXT: nc_r[i] <= quo;
              OP_STEP: begin
                cstep_r[i] <= quo;
                neg_r[i]   <= a_d[31];
              end
              default: ;
            endcase
          end
        end
      end
      if (cmd.walk) begin
        cnt_r <= cnt_r + CNT_W'(1);
        for (int i = 0; i < 3; i++) begin
          if (k == 2'(i)) begin
            nc_r[i]   <= nc_new;
            cell_r[i] <= cell_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.walk || cmd.load_miss) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      out_cell_x     <= cell_r[0][3:0];
      out_cell_y     <= cell_r[1][3:0];
      out_cell_z     <= cell_r[2][3:0];
      out_cell_index <= idx;
      out_t_limit    <= lim;
      out_missed     <= 1'b0;
      out_last       <= walk_end;
    end else if (cmd.load_miss) begin
      out_cell_x     <= '0;
      out_cell_y     <= '0;
      out_cell_z     <= '0;
      out_cell_index <= '0;
      out_t_limit    <= '0;
      out_missed     <= 1'b1;
      out_last       <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.div_done = div_done;
  assign sts.walk_end = walk_end;

endmodule
`default_nettype wire

@@ design/vgrw_ctrl.sv @@
// Controller: accepts rays, sequences the nine setup divisions and cell-size loads, then the walk.
// Depends on vgrw_pkg.
`default_nettype none
module vgrw_ctrl import vgrw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_box_hit,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {ST_IDLE, ST_MISS, ST_DIV_GO, ST_DIV_WAIT, ST_WALK} state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [1:0] ax_r, ax_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ax_nxt    = ax_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_box_hit) begin
            state_nxt = ST_DIV_GO;
            op_nxt    = OP_CELL;
            ax_nxt    = '0;
          end else begin
            state_nxt = ST_MISS;
          end
        end
      end
      ST_MISS: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_DIV_GO: begin
        if (op_r == OP_CS) begin
          op_nxt = OP_NEXT;
        end else begin
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_DIV_GO;
          case (op_r)
            OP_CELL: op_nxt = OP_CS;
            OP_NEXT: op_nxt = OP_STEP;
            default: begin
              op_nxt = OP_CELL;
              if (ax_r == AX_LAST) begin
                state_nxt = ST_WALK;
              end else begin
                ax_nxt = ax_r + 2'd1;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (sts.out_free && sts.walk_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_CELL;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ax_r    <= ax_nxt;
    end
  end

  assign in_stall      = state_r != ST_IDLE;
  assign cmd.accept    = (state_r == ST_IDLE) && in_valid;
  assign cmd.div_start = (state_r == ST_DIV_GO) && (op_r != OP_CS);
  assign cmd.cs_load   = (state_r == ST_DIV_GO) && (op_r == OP_CS);
  assign cmd.op        = op_r;
  assign cmd.ax        = ax_r;
  assign cmd.walk      = (state_r == ST_WALK) && sts.out_free;
  assign cmd.load_miss = (state_r == ST_MISS) && sts.out_free;

endmodule
`default_nettype wire

@@ design/voxel_grid_ray_walker.sv @@
// Voxel grid ray walker top level: 3D DDA traversal of a Q16.16 voxel grid.
// Depends on vgrw_pkg, vgrw_ctrl, vgrw_dp.
//
// Input channel (in_*): one ray per transfer, taken when in_valid is high and
// in_stall is low. in_stall stays high from the transfer until the ray's last
// result has been loaded into the output register.
// Result channel (out_*): one voxel per transfer, out_last on the final one; a
// ray with in_box_hit low gives a single result with out_missed and out_last.
// Configuration (cfg_*): cfg_ready is always high; write only while idle.
// A missed ray goes through the miss state into the output register. A hit ray runs
// nine divisions on one bit-serial divider and three cell-size loads, then gives one
// voxel per cycle while the output register is free, at most 46 voxels.
// The divider is shared, so a new ray is taken only after the previous ray's last
// result has been loaded into the output register.
// When out_stall is high a valid result in the register holds and the walk pauses.
// Reset (rst_n low, synchronous) empties the output register, returns to idle
// and restores the grid to min 0, width 1.0 on each axis.
`default_nettype none
module voxel_grid_ray_walker import vgrw_pkg::*; #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [31:0]   in_origin_x,
  input  wire logic signed [31:0]   in_origin_y,
  input  wire logic signed [31:0]   in_origin_z,
  input  wire logic signed [31:0]   in_entry_x,
  input  wire logic signed [31:0]   in_entry_y,
  input  wire logic signed [31:0]   in_entry_z,
  input  wire logic signed [31:0]   in_dir_x,
  input  wire logic signed [31:0]   in_dir_y,
  input  wire logic signed [31:0]   in_dir_z,
  input  wire logic                 in_box_hit,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [3:0]                out_cell_x,
  output logic [3:0]                out_cell_y,
  output logic [3:0]                out_cell_z,
  output logic [11:0]               out_cell_index,
  output logic [30:0]               out_t_limit,
  output logic                      out_missed,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vgrw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_box_hit (in_box_hit),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  vgrw_dp #(
    .CELLS_X (CELLS_X),
    .CELLS_Y (CELLS_Y),
    .CELLS_Z (CELLS_Z)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_origin_z    (in_origin_z),
    .in_entry_x     (in_entry_x),
    .in_entry_y     (in_entry_y),
    .in_entry_z     (in_entry_z),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_cell_z     (out_cell_z),
    .out_cell_index (out_cell_index),
    .out_t_limit    (out_t_limit),
    .out_missed     (out_missed),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

@@ design/vgrw_chk.sv @@
// Port-level checker for the voxel grid ray walker, bound to the top level.
// Depends on voxel_grid_ray_walker_defines.svh.
`default_nettype none
`include "voxel_grid_ray_walker_defines.svh"
module vgrw_chk #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Y = 16,
  parameter int CELLS_Z = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_cell_x,
  input wire logic [3:0]  out_cell_y,
  input wire logic [3:0]  out_cell_z,
  input wire logic [11:0] out_cell_index,
  input wire logic [30:0] out_t_limit,
  input wire logic        out_missed,
  input wire logic        out_last
);

  logic [11:0] exp_idx;
  logic        cz_ok;

  assign exp_idx = 12'(out_cell_x) + 12'(out_cell_y) * 12'(CELLS_X)
                 + 12'(out_cell_z) * 12'(CELLS_X * CELLS_Y);
  assign cz_ok   = 32'(out_cell_z) < CELLS_Z;

  `VGRW_ASSERT_NOW(a_miss_final, out_valid && out_missed, out_last && out_cell_index == 12'd0 && out_t_limit == 31'd0, "miss result malformed")
  `VGRW_ASSERT_NOW(a_index_match, out_valid && !out_missed, out_cell_index == exp_idx && cz_ok, "cell index mismatch")
  `VGRW_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "ray transfer not followed by busy")
  `VGRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_cell_index) && $stable(out_last), "stalled result changed")

endmodule

bind voxel_grid_ray_walker vgrw_chk #(
  .CELLS_X (CELLS_X),
  .CELLS_Y (CELLS_Y),
  .CELLS_Z (CELLS_Z)
) u_chk (.*);
`default_nettype wire

@@ bench/tb_voxel_grid_ray_walker.sv @@
// Self-checking testbench for voxel_grid_ray_walker: rays are driven over the
// valid/stall channel and every voxel transfer is compared with a local DDA walker.
// Depends on vgrw_pkg and the voxel_grid_ray_walker RTL.
`timescale 1ns / 1ps
module tb_voxel_grid_ray_walker;
  import vgrw_pkg::*;

  localparam int    NCELL    = 16;
  localparam longint SAT     = 64'h7FFFFFFF;
  localparam int    N_PHASES = 6;
  localparam int    PER_PHASE = 25;

  typedef struct {
    logic signed [31:0] org[3];
    logic signed [31:0] ent[3];
    logic signed [31:0] dir[3];
    logic               hit;
    bit                 typed;
  } ray_t;

  typedef struct packed {
    logic [3:0]  cx;
    logic [3:0]  cy;
    logic [3:0]  cz;
    logic [11:0] idx;
    logic [30:0] tlim;
    logic        missed;
    logic        last;
  } voxel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_entry_x = '0, in_entry_y = '0, in_entry_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic in_box_hit = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_cell_x, out_cell_y, out_cell_z;
  logic [11:0] out_cell_index;
  logic [30:0] out_t_limit;
  logic out_missed, out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_X;
  logic [31:0] cfg_data = '0;

  voxel_grid_ray_walker u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  longint grid_lo[3];
  longint grid_span[3];
  voxel_t expected_voxels[$];
  int     n_errors = 0;
  int     n_rays = 0;
  int     n_voxels = 0;
  int     n_misses = 0;
  bit     quiet = 1'b0;

  function automatic longint sat_div(longint num, longint den);
    longint q;
    if (den == 0) return SAT;
    q = num / den;
    return (q > SAT) ? SAT : q;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return (a + b > SAT) ? SAT : a + b;
  endfunction

  function automatic void setup_axis(input longint mn, input longint w, input longint p,
                                     input longint d, output int cell_o, output longint nxt,
                                     output longint stp, output bit neg);
    longint off, plane, pl_dist, c, cs, ad;
    if (w == 0) w = 1;
    off = p - mn;
    c = 0;
    if (off > 0) begin
      c = (off * NCELL) / w;
      if (c > NCELL - 1) c = NCELL - 1;
    end
    cs = w / NCELL;
    neg = d < 0;
    plane = mn + cs * (c + (neg ? 0 : 1));
    pl_dist = plane - p;
    if (pl_dist < 0) pl_dist = -pl_dist;
    ad = (d < 0) ? -d : d;
    cell_o = int'(c);
    nxt = sat_div(pl_dist <<< 16, ad);
    stp = sat_div(cs <<< 16, ad);
  endfunction

  function automatic bit strictly_in(longint o, longint mn, longint w);
    return o > mn && o < mn + w;
  endfunction

  function automatic void walk_ray(ray_t r);
    longint p[3], tc[3], ts[3];
    int     c[3];
    bit     ng[3];
    bit     use_org;
    int     count, a;
    voxel_t v;
    use_org = 1'b1;
    for (int i = 0; i < 3; i++)
      if (!strictly_in(longint'(r.org[i]), grid_lo[i], grid_span[i])) use_org = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p[i] = use_org ? longint'(r.org[i]) : longint'(r.ent[i]);
      setup_axis(grid_lo[i], grid_span[i], p[i], longint'(r.dir[i]), c[i], tc[i], ts[i],
                 ng[i]);
    end
    count = 0;
    while (c[0] >= 0 && c[0] < NCELL && c[1] >= 0 && c[1] < NCELL &&
           c[2] >= 0 && c[2] < NCELL && count < MAX_VISITS) begin
      v.cx = c[0][3:0];
      v.cy = c[1][3:0];
      v.cz = c[2][3:0];
      v.idx = 12'(c[0] + c[1] * NCELL + c[2] * NCELL * NCELL);
      v.missed = 1'b0;
      v.last = 1'b0;
      if (tc[0] < tc[1] && tc[0] < tc[2]) a = 0;
      else if (tc[1] < tc[2]) a = 1;
      else a = 2;
      v.tlim = tc[a][30:0];
      tc[a] = sat_add(tc[a], ts[a]);
      c[a] += ng[a] ? -1 : 1;
      expected_voxels.push_back(v);
      count++;
    end
    if (count > 0) expected_voxels[$].last = 1'b1;
  endfunction

  function automatic ray_t mk_ray(logic signed [31:0] ox, oy, oz, ex, ey, ez, dx, dy, dz,
                                  logic hit, bit typed = 1'b0);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.ent = '{ex, ey, ez};
    r.dir = '{dx, dy, dz};
    r.hit = hit;
    r.typed = typed;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_dir();
    logic signed [31:0] d;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = $urandom;
      default: d = 32'($urandom_range(1, 32'h3FFFF)) << $urandom_range(0, 8);
    endcase
    if ($urandom_range(0, 1)) d = -d;
    return d;
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    int   face;
    r = mk_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    case ($urandom_range(0, 9))
      0: begin
        r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end
      1: begin
        r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, 1'b0);
      end
      2, 3, 4: begin
        for (int i = 0; i < 3; i++) begin
          r.org[i] = 32'(grid_lo[i] + $urandom_range(0, 32'(grid_span[i])));
          r.ent[i] = $urandom;
          r.dir[i] = rand_dir();
        end
      end
      default: begin
        face = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          r.org[i] = $urandom;
          r.ent[i] = 32'(grid_lo[i] + $urandom_range(0, 32'(grid_span[i])));
          r.dir[i] = rand_dir();
        end
        r.ent[face] = 32'(grid_lo[face] + ($urandom_range(0, 1) ? grid_span[face] : 0));
      end
    endcase
    return r;
  endfunction

  task automatic send_ray(ray_t r);
    voxel_t v;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_origin_x, in_origin_y, in_origin_z} <= {r.org[0], r.org[1], r.org[2]};
    {in_entry_x, in_entry_y, in_entry_z} <= {r.ent[0], r.ent[1], r.ent[2]};
    {in_dir_x, in_dir_y, in_dir_z} <= {r.dir[0], r.dir[1], r.dir[2]};
    in_box_hit <= r.hit;
    do @(posedge clk); while (in_stall);
    n_rays++;
    if (!r.hit) n_misses++;
    if (r.typed) begin
      v = '{cx: 4'd0, cy: 4'd0, cz: 4'd0, idx: 12'd0, tlim: 31'd0, missed: 1'b1, last: 1'b1};
      expected_voxels.push_back(v);
    end else if (!r.hit) begin
      v = '0;
      v.missed = 1'b1;
      v.last = 1'b1;
      expected_voxels.push_back(v);
    end else begin
      walk_ray(r);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_voxels.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_grid(logic [31:0] mins[3], logic [31:0] spans[3]);
    logic [CFG_IDX_W-1:0] idx[6];
    logic [31:0] val[6];
    idx = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_WID_X, REG_WID_Y, REG_WID_Z};
    val = '{mins[0], mins[1], mins[2], spans[0], spans[1], spans[2]};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      if (i < 3) grid_lo[i] = longint'(signed'(val[i]));
      else grid_span[i - 3] = longint'(val[i][30:0]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic chk(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    voxel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_voxels.size() == 0) begin
        $error("unexpected result transfer: cell %0d", out_cell_index);
        n_errors++;
      end else begin
        e = expected_voxels.pop_front();
        n_voxels++;
        chk("cell_x", e.cx, out_cell_x);
        chk("cell_y", e.cy, out_cell_y);
        chk("cell_z", e.cz, out_cell_z);
        chk("cell_index", e.idx, out_cell_index);
        chk("t_limit", e.tlim, out_t_limit);
        chk("missed", e.missed, out_missed);
        chk("last", e.last, out_last);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    logic s;
    s = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      s = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 17);
      s = 1'b1;
    end
    out_stall <= s;
  end

  initial begin
    #(64'd1_000_000 * 12);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    ray_t        rows[$];
    logic [31:0] mins[3];
    logic [31:0] spans[3];
    grid_lo = '{0, 0, 0};
    grid_span = '{65536, 65536, 65536};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
    rows.push_back(mk_ray(32'h80000000, 32'h7FFFFFFF, '1, 32'h7FFFFFFF, 32'h80000000, '1,
                          '1, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b1));
    rows.push_back(mk_ray(32'h8000, 32'h8000, 32'h8000, '0, '0, '0, 32'h10000, '0, '0, 1'b1));
    rows.push_back(mk_ray(32'h8000, 32'h8000, 32'h8000, '0, '0, '0, -32'sh10000, '0, '0,
                          1'b1));
    rows.push_back(mk_ray(32'h8000, 32'h8000, 32'h8000, '0, '0, '0, '0, '0, '0, 1'b1));
    rows.push_back(mk_ray(32'h1234, 32'h9876, 32'hF00, '0, '0, '0, 32'h80000000, 32'h7FFFFFFF,
                          32'h80000000, 1'b1));
    rows.push_back(mk_ray(-32'sh10000, '0, '0, '0, '0, '0, 32'h10000, 32'h10000, 32'h10000,
                          1'b1));
    rows.push_back(mk_ray('0, '0, '0, 32'h10000, 32'h10000, 32'h10000, -32'sh10000,
                          -32'sh10000, -32'sh10000, 1'b1));
    rows.push_back(mk_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h3000, 32'h2000, 32'h1000, 1'b1));
    rows.push_back(mk_ray(32'h10000, 32'h4000, 32'h4000, 32'h7FFFFFFF, 32'h4000, 32'h4000,
                          -32'sh1, 32'h1, 32'h0, 1'b1));
    rows.push_back(mk_ray(32'h1, 32'hFFFF, 32'h8000, '0, '0, '0, 32'h5555, -32'sh3333,
                          32'h7777, 1'b1));
    rows.push_back(mk_ray(32'h8000, 32'h8000, 32'h8000, '0, '0, '0, 32'h10000, 32'h10000,
                          32'h10000, 1'b1));
    foreach (rows[i]) send_ray(rows[i]);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          mins = '{'0, '0, '0};
          spans = '{32'h100000, 32'h100000, 32'h100000};
        end
        1: begin
          mins = '{32'h80000000, 32'h80000000, 32'h80000000};
          spans = '{32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF};
        end
        2: begin
          mins = '{32'h7FFFFFFF, '1, '0};
          spans = '{32'h80000000, 32'h0, 32'h80000001};
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            mins[i] = $urandom;
            spans[i] = {1'($urandom_range(0, 1)), 31'($urandom_range(32'h1000, 32'h2000000))};
          end
        end
      endcase
      write_grid(mins, spans);
      if (ph == N_PHASES - 1) quiet = 1'b1;
      repeat (PER_PHASE) send_ray(rand_ray());
      drain();
    end

    $display("Covered %0d rays (%0d misses) giving %0d voxel transfers over %0d grid setups.",
             n_rays, n_misses, n_voxels, N_PHASES + 1);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/vgrw_pkg.sv
design/vgrw_div.sv
design/vgrw_dp.sv
design/vgrw_ctrl.sv
design/voxel_grid_ray_walker.sv
design/vgrw_chk.sv
bench/tb_voxel_grid_ray_walker.sv
